>>> sv/sepd_pkg.sv
// ----------------------------------------------------------------------------
// sepd_pkg
// Shared constants and types for the start/end delimited frame deframer.
// ----------------------------------------------------------------------------
package sepd_pkg;

  localparam int MAX_LEN   = 32;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] n;
    logic [1:0]       status;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } free_t;

endpackage

>>> sv/sepd_front.sv
// ----------------------------------------------------------------------------
// sepd_front
// Accepts received bytes, tracks frame state and parity, writes payload into
// the current buffer bank and hands a descriptor to the queue on frame close.
// ----------------------------------------------------------------------------
module sepd_front
  import sepd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  output wr_t                  mem_wr,
  output logic                 push,
  output desc_t                push_desc,
  input  free_t                bank_free
);

  logic [7:0]       start_r, start_nxt;
  logic [7:0]       end_r, end_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       par_r, par_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic             accept;
  logic             store;
  logic             close;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] n_cnt;
  logic [IDX_W-1:0] n_keep;
  logic [7:0]       par_upd;

  assign in_tready = !busy_r[bank_r];
  assign accept    = in_tvalid && in_tready;
  assign store     = in_frame_r && (in_tdata != end_r);
  assign cnt_inc   = cnt_r + 1'b1;
  assign close     = in_frame_r && (!store || (cnt_inc == CNT_W'(MAX_LEN)));
  assign n_cnt     = store ? cnt_inc : cnt_r;
  assign n_keep    = (n_cnt == '0) ? '0 : IDX_W'(n_cnt - 1'b1);
  assign par_upd   = par_r ^ in_tdata;

  assign mem_wr.en   = accept && store;
  assign mem_wr.addr = {bank_r, cnt_r[IDX_W-1:0]};
  assign mem_wr.data = in_tdata;

  assign push             = accept && close;
  assign push_desc.bank   = bank_r;
  assign push_desc.n      = n_keep;
  assign push_desc.status = (n_keep == '0) ? ST_EMPTY :
                            ((par_upd == 8'h00) ? ST_GOOD : ST_BAD);

  always_comb begin
    start_nxt    = start_r;
    end_nxt      = end_r;
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    par_nxt      = par_r;
    bank_nxt     = bank_r;
    busy_nxt     = busy_r;
    if (cfg_we) begin
      if (cfg_index == REG_START_BYTE) begin
        start_nxt = cfg_wdata;
      end else if (cfg_index == REG_END_BYTE) begin
        end_nxt = cfg_wdata;
      end
    end
    if (bank_free.valid) begin
      busy_nxt[bank_free.bank] = 1'b0;
    end
    if (accept) begin
      if (!in_frame_r) begin
        if (in_tdata == start_r) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
          par_nxt      = start_r;
        end
      end else if (close) begin
        in_frame_nxt     = 1'b0;
        cnt_nxt          = '0;
        par_nxt          = 8'h00;
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else begin
        cnt_nxt = n_cnt;
        par_nxt = par_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= START_BYTE_RST;
      end_r      <= END_BYTE_RST;
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      par_r      <= 8'h00;
      bank_r     <= 1'b0;
      busy_r     <= 2'b00;
    end else begin
      start_r    <= start_nxt;
      end_r      <= end_nxt;
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      par_r      <= par_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_free_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bank_free.valid |-> busy_r[bank_free.bank])
    else $error("bank released that was not busy");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !busy_r[bank_r] && in_frame_r)
    else $error("frame closed into a busy bank");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_LEN))
    else $error("stored count reached buffer size while open");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r == '0 && par_r == 8'h00 && !in_frame_r)
    else $error("frame state not cleared after close");
`endif

endmodule

>>> sv/sepd_queue.sv
// ----------------------------------------------------------------------------
// sepd_queue
// Two-entry descriptor queue between the collecting front and draining back.
// ----------------------------------------------------------------------------
module sepd_queue
  import sepd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  q_valid,
  output desc_t q_desc
);

  desc_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign q_valid = (cnt_r != 2'd0);
  assign q_desc  = q_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sv/sepd_back.sv
// ----------------------------------------------------------------------------
// sepd_back
// Holds the two-bank frame buffer and drains closed frames onto the output
// stream through a registered read stage and an output register.
// ----------------------------------------------------------------------------
module sepd_back
  import sepd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  wr_t        mem_wr,
  input  logic       q_valid,
  input  desc_t      q_desc,
  output logic       pop,
  output free_t      bank_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  logic [7:0] mem_r [2**ADDR_W];

  logic             run_r, run_nxt;
  logic             bank_r, bank_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r;
  logic [1:0]       s1_status_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic [1:0]       out_status_r;

  logic s1_move;
  logic s1_free;
  logic issue;
  logic last_issue;

  assign s1_move    = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_free    = !s1_valid_r || s1_move;
  assign issue      = run_r && s1_free;
  assign last_issue = (n_r == '0) || (idx_r == (n_r - 1'b1));
  assign pop        = !run_r && q_valid;

  assign bank_free.valid = issue && last_issue;
  assign bank_free.bank  = bank_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    run_nxt       = run_r;
    bank_nxt      = bank_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      s1_valid_nxt  = 1'b0;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
      idx_nxt      = idx_r + 1'b1;
      if (last_issue) begin
        run_nxt = 1'b0;
      end
    end
    if (pop) begin
      run_nxt    = 1'b1;
      bank_nxt   = q_desc.bank;
      n_nxt      = q_desc.n;
      status_nxt = q_desc.status;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem_r[mem_wr.addr] <= mem_wr.data;
    end
    if (issue) begin
      rd_data_r <= mem_r[{bank_r, idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    bank_r   <= bank_nxt;
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (issue) begin
      s1_last_r   <= last_issue;
      s1_status_r <= status_r;
    end
    if (s1_move) begin
      out_data_r   <= (s1_status_r == ST_EMPTY) ? 8'h00 : rd_data_r;
      out_last_r   <= s1_last_r;
      out_status_r <= s1_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_EMPTY) |-> out_last_r && out_data_r == 8'h00)
    else $error("empty frame result malformed");
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && (status_r == ST_EMPTY) |-> n_r == '0)
    else $error("empty status on a frame with payload");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !run_r && q_valid)
    else $error("descriptor taken while draining");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last_issue |=> !run_r || $past(pop))
    else $error("drain continued past last byte");
`endif

endmodule

>>> sv/start_end_frame_parity_deframer_core.sv
// ----------------------------------------------------------------------------
// start_end_frame_parity_deframer_core
// Start/end delimited frame receiver with XOR parity check.
// ----------------------------------------------------------------------------
// Raw link bytes enter on the in_ stream, one per transfer. A frame opens on
// the start byte and closes on the end byte or when the buffer holds MAX_LEN
// bytes; the last stored byte is the parity byte and is dropped.
// Each closed frame leaves on the out_ stream as one transfer per payload
// byte, with tlast on the final one and the status in tuser on every one.
// An empty frame gives a single transfer with data 0 and status empty.
// Input is accepted at one byte per cycle. A closed frame is drained from one
// buffer bank at one byte per cycle while the receiver is ready, as the next
// frame is collected in the other bank; the input stalls only when the bank
// it would fill is still being drained. With the drain idle, a closed frame
// passes the queue, drain control, read stage and output register. A receiver
// stall holds the output register and backs up the drain; input keeps flowing
// until both banks are full. The user must write start_byte (index 0) and
// end_byte (index 1) on the cfg_ port only while the block is idle; the block
// does not enforce it. Reset (rst_n low, synchronous) returns to idle with
// start_byte 2 and end_byte 3; there is no clearing pass.
// ----------------------------------------------------------------------------
module start_end_frame_parity_deframer_core
  import sepd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] payload_byte
  output logic                 out_tlast,
  output logic [1:0]           out_tuser   // [1:0] frame_status
);

  wr_t   mem_wr;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  q_valid;
  desc_t q_desc;
  free_t bank_free;

  sepd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .mem_wr    (mem_wr),
    .push      (push),
    .push_desc (push_desc),
    .bank_free (bank_free)
  );

  sepd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  sepd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .pop        (pop),
    .bank_free  (bank_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> verif/start_end_frame_parity_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// start_end_frame_parity_deframer_core_tb
// Self-checking testbench for the start/end delimited frame deframer.
// ----------------------------------------------------------------------------
// A short table of directed bytes covers empty frames, good and bad parity and
// a start byte inside a frame. Random frames follow under several delimiter
// settings, with full-buffer, truncated and noisy sequences mixed in. A
// behavioral model of the deframer predicts each output the table does not
// give, and a monitor compares each transfer with the oldest expectation. The
// sender runs in random bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module start_end_frame_parity_deframer_core_tb
  import sepd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_ROWS = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } payload_beat_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          fixed;
    payload_beat_t beat;
  } stim_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam payload_beat_t NO_BEAT = '0;

  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{8'h00, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'h03, 1'b1, '{8'h00, 1'b1, ST_EMPTY}},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, NO_BEAT},
    '{8'h03, 1'b1, '{8'h00, 1'b1, ST_EMPTY}},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'hA5, 1'b0, NO_BEAT},
    '{8'hA4, 1'b0, NO_BEAT},
    '{8'h03, 1'b1, '{8'hA5, 1'b1, ST_GOOD}},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h03, 1'b1, '{8'h5A, 1'b1, ST_BAD}},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'h02, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h03, 1'b0, NO_BEAT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic [1:0]           out_tuser;

  start_end_frame_parity_deframer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Deframer model state.
  logic [7:0]  start_byte_q = START_BYTE_RST;
  logic [7:0]  end_byte_q = END_BYTE_RST;
  bit          in_frm = 1'b0;
  int unsigned n_stored = 0;
  logic [7:0]  parity_acc = '0;
  logic [7:0]  frame_buf [MAX_LEN];

  payload_beat_t predicted_beats[$];
  payload_beat_t expected_beats[$];

  int       errors = 0;
  int       items_sent = 0;
  int       cycles = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(10, 80);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_mode_left % 5 == 0);
      default:   out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    payload_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected transfer: payload_byte %0h last %0b frame_status %0d",
               out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata !== want.data) begin
          $error("payload_byte: expected %0h, actual %0h", want.data, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("frame_status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  // Advances the model by one received byte and queues the frame's payload
  // when the byte closes it. Returns whether the byte did any work.
  function automatic bit deframe_byte(input logic [7:0] b);
    int unsigned n;
    logic [1:0]  st;
    payload_beat_t beat;
    if (!in_frm) begin
      if (b == start_byte_q) begin
        in_frm = 1'b1;
        n_stored = 0;
        parity_acc = start_byte_q;
        return 1'b1;
      end
      return 1'b0;
    end
    parity_acc = parity_acc ^ b;
    if (b != end_byte_q && n_stored < MAX_LEN) begin
      frame_buf[n_stored] = b;
      n_stored++;
    end
    if (b != end_byte_q && n_stored < MAX_LEN) return 1'b1;
    n = (n_stored > 0) ? n_stored - 1 : 0;
    st = (parity_acc == 8'h00) ? ST_GOOD : ST_BAD;
    in_frm = 1'b0;
    n_stored = 0;
    parity_acc = 8'h00;
    if (n == 0) begin
      beat = '{8'h00, 1'b1, ST_EMPTY};
      predicted_beats.push_back(beat);
    end else begin
      for (int k = 0; k < n; k++) begin
        beat = '{frame_buf[k], (k + 1 == n), st};
        predicted_beats.push_back(beat);
      end
    end
    return 1'b1;
  endfunction

  task automatic pace();
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fixed,
                           input payload_beat_t beat);
    bit counted;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predicted_beats.delete();
    counted = deframe_byte(b);
    if (fixed) begin
      expected_beats.push_back(beat);
    end else begin
      foreach (predicted_beats[i]) expected_beats.push_back(predicted_beats[i]);
    end
    if (counted) items_sent++;
    pace();
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic wait_idle();
    if (in_frm) send_byte(end_byte_q, 1'b0, NO_BEAT);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_BYTE) start_byte_q = val;
    else if (idx == REG_END_BYTE) end_byte_q = val;
  endtask

  // A frame of len payload bytes, a parity byte and, if with_end is set and the
  // buffer has room, the end byte. Clean frames keep the end byte out of payload.
  task automatic send_frame(input int len, input bit good, input bit with_end,
                            input bit clean);
    logic [7:0] acc;
    logic [7:0] pb;
    acc = start_byte_q;
    send_byte(start_byte_q, 1'b0, NO_BEAT);
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) pb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if (clean && pb == end_byte_q) pb = ~pb;
      acc = acc ^ pb;
      send_byte(pb, 1'b0, NO_BEAT);
    end
    if (len < MAX_LEN - 1) acc = acc ^ end_byte_q;
    if (!good) acc = acc ^ 8'($urandom_range(1, 255));
    send_byte(acc, 1'b0, NO_BEAT);
    if (with_end && len < MAX_LEN - 1) send_byte(end_byte_q, 1'b0, NO_BEAT);
  endtask

  task automatic run_random(input int n_items);
    int target;
    int r;
    int len;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 15);
      if (r < 2) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, NO_BEAT);
      end else begin
        if (r == 2) len = MAX_LEN - 1;
        else if (r == 3) len = $urandom_range(MAX_LEN, MAX_LEN + 6);
        else len = $urandom_range(0, 6);
        send_frame(len, $urandom_range(0, 3) != 0, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 7) != 0);
      end
      if ($urandom_range(0, 11) == 0) drain_outputs();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].beat);
    end
    run_random(15);

    // Writes to the unused indexes must leave the delimiters alone.
    wait_idle();
    write_reg(REG_SPARE_2, 8'h41);
    write_reg(REG_SPARE_3, 8'hC2);
    run_random(5);

    wait_idle();
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hFF);
    send_frame(MAX_LEN - 1, 1'b1, 1'b1, 1'b1);
    run_random(15);

    wait_idle();
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h00);
    run_random(15);

    wait_idle();
    write_reg(REG_START_BYTE, 8'h7E);
    write_reg(REG_END_BYTE, 8'h7E);
    run_random(15);

    wait_idle();
    write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_END_BYTE, 8'($urandom_range(0, 255)));
    run_random(15);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
